@@ design/sbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants for the serial bank switch mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  // Work RAM geometry
  localparam int WORK_RAM_DEPTH = 8192;
  localparam int RAM_AW         = $clog2(WORK_RAM_DEPTH);

  // Payload widths
  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int MADDR_W = 18;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRG_COUNT = 1'b0,
    CFG_CHR_COUNT = 1'b1
  } cfg_index_t;

  // Access commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CPU_READ  = 3'd0,
    CMD_CPU_WRITE = 3'd1,
    CMD_PPU_READ  = 3'd2,
    CMD_PPU_WRITE = 3'd3,
    CMD_REINIT    = 3'd4
  } cmd_t;

  // Serial load targets, address bits 14:13
  localparam logic [1:0] TGT_CONTROL  = 2'd0;
  localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
  localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
  localparam logic [1:0] TGT_PRG      = 2'd3;

  // Program banking modes, control bits 3:2
  localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
  localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  localparam logic [4:0] CONTROL_RESET   = 5'h1C;
  localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
  localparam logic [2:0] SHIFT_LAST      = 3'd4;

endpackage

@@ design/sbsm_ifs.sv @@
// ----------------------------------------------------------------------------
// sbsm_ifs
// Valid/ready channels for mapper access beats and result beats.
// ----------------------------------------------------------------------------
interface sbsm_req_if
  import sbsm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, cmd, address, write_data, input ready);
  modport sink   (input valid, cmd, address, write_data, output ready);
endinterface

interface sbsm_rsp_if
  import sbsm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               mapped;
  logic [MADDR_W-1:0] mapped_address;
  logic               ram_hit;
  logic [DATA_W-1:0]  read_data;
  logic [1:0]         mirror_mode;

  modport source (output valid, mapped, mapped_address, ram_hit, read_data, mirror_mode,
                  input ready);
  modport sink   (input valid, mapped, mapped_address, ram_hit, read_data, mirror_mode,
                  output ready);
endinterface

@@ design/serial_bank_switch_mapper.sv @@
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper
// Bank switching cartridge mapper with a five-beat serial load register.
// ----------------------------------------------------------------------------
// Usage: one access beat (CPU read/write, PPU read/write, reinit) is taken
// per clock when the result side does not stall, and one result beat comes
// back for each, in order. Stage 1 registers the beat and performs the
// single-port work RAM access (read data registered); the result register
// stage translates the address and updates the bank registers. After reset
// the block sweeps the work RAM to zero, one byte per cycle, with req.ready
// low; configuration writes are taken throughout. Configure only while
// idle. mirror_mode reports control bits 1:0 after the beat took effect.
module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  sbsm_req_if.sink              req,
  sbsm_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0] prg_count;
  logic [5:0] chr_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count <= PRG_COUNT_RESET;
      chr_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PRG_COUNT: prg_count <= cfg_data[4:0];
        CFG_CHR_COUNT: chr_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // last 16 KiB bank, wraps to 4 bits
  logic [3:0] last_prg;
  assign last_prg = prg_count[3:0] - 4'd1;

  // --------------------------------------------------------------------------
  // Clearing sweep after reset
  // --------------------------------------------------------------------------
  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == RAM_AW'(WORK_RAM_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic accept;
  logic rsp_valid;

  assign s1_adv    = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || s1_adv);
  assign accept    = req.valid && req.ready;

  // work RAM window is 0x6000-0x7FFF
  logic in_ram_win;
  logic ram_we;
  assign in_ram_win = (req.address[15:13] == 3'b011);
  assign ram_we     = accept && (cmd_t'(req.cmd) == CMD_CPU_WRITE) && in_ram_win;

  // --------------------------------------------------------------------------
  // Stage 1: registered beat and work RAM access
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] wram [WORK_RAM_DEPTH];
  logic [CMD_W-1:0]  s1_cmd;
  logic [ADDR_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_data;
  logic [DATA_W-1:0] s1_rdata;

  always_ff @(posedge clk) begin
    if (clearing) begin
      wram[clr_addr] <= '0;
    end else if (ram_we) begin
      wram[req.address[RAM_AW-1:0]] <= req.write_data;
    end
    if (accept) s1_rdata <= wram[req.address[RAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= req.cmd;
      s1_addr <= req.address;
      s1_data <= req.write_data;
    end
  end

  // --------------------------------------------------------------------------
  // Mapper registers
  // --------------------------------------------------------------------------
  logic [4:0] control_reg,    control_reg_next;
  logic [4:0] shift_value,    shift_value_next;
  logic [2:0] shift_count,    shift_count_next;
  logic [4:0] chr_bank_low,   chr_bank_low_next;
  logic [4:0] chr_bank_high,  chr_bank_high_next;
  logic [4:0] chr_bank_whole, chr_bank_whole_next;
  logic [2:0] prg_bank_whole, prg_bank_whole_next;
  logic [3:0] prg_bank_low,   prg_bank_low_next;
  logic [3:0] prg_bank_high,  prg_bank_high_next;

  logic [4:0] shift_new;
  assign shift_new = {s1_data[0], shift_value[4:1]};

  always_comb begin
    control_reg_next    = control_reg;
    shift_value_next    = shift_value;
    shift_count_next    = shift_count;
    chr_bank_low_next   = chr_bank_low;
    chr_bank_high_next  = chr_bank_high;
    chr_bank_whole_next = chr_bank_whole;
    prg_bank_whole_next = prg_bank_whole;
    prg_bank_low_next   = prg_bank_low;
    prg_bank_high_next  = prg_bank_high;
    case (cmd_t'(s1_cmd))
      CMD_CPU_WRITE: begin
        if (s1_addr[15]) begin
          if (s1_data[7]) begin
            // serial reset, forces fix-last program mode
            shift_value_next = '0;
            shift_count_next = '0;
            control_reg_next = control_reg | 5'b01100;
          end else if (shift_count == SHIFT_LAST) begin
            // fifth beat: commit to the selected register
            shift_value_next = '0;
            shift_count_next = '0;
            case (s1_addr[14:13])
              TGT_CONTROL: control_reg_next = shift_new;
              TGT_CHR_LOW: begin
                if (control_reg[4]) chr_bank_low_next = shift_new;
                else chr_bank_whole_next = {shift_new[4:1], 1'b0};
              end
              TGT_CHR_HIGH: begin
                if (control_reg[4]) chr_bank_high_next = shift_new;
              end
              default: begin
                case (control_reg[3:2])
                  PRG_MODE_32K_A, PRG_MODE_32K_B: prg_bank_whole_next = shift_new[3:1];
                  PRG_MODE_FIX_FIRST: begin
                    prg_bank_low_next  = '0;
                    prg_bank_high_next = shift_new[3:0];
                  end
                  default: begin
                    prg_bank_low_next  = shift_new[3:0];
                    prg_bank_high_next = last_prg;
                  end
                endcase
              end
            endcase
          end else begin
            shift_value_next = shift_new;
            shift_count_next = shift_count + 3'd1;
          end
        end
      end
      CMD_REINIT: begin
        control_reg_next    = CONTROL_RESET;
        shift_value_next    = '0;
        shift_count_next    = '0;
        chr_bank_low_next   = '0;
        chr_bank_high_next  = '0;
        chr_bank_whole_next = '0;
        prg_bank_whole_next = '0;
        prg_bank_low_next   = '0;
        prg_bank_high_next  = last_prg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg    <= CONTROL_RESET;
      shift_value    <= '0;
      shift_count    <= '0;
      chr_bank_low   <= '0;
      chr_bank_high  <= '0;
      chr_bank_whole <= '0;
      prg_bank_whole <= '0;
      prg_bank_low   <= '0;
      prg_bank_high  <= 4'hF;  // count resets to 16
    end else if (s1_adv) begin
      control_reg    <= control_reg_next;
      shift_value    <= shift_value_next;
      shift_count    <= shift_count_next;
      chr_bank_low   <= chr_bank_low_next;
      chr_bank_high  <= chr_bank_high_next;
      chr_bank_whole <= chr_bank_whole_next;
      prg_bank_whole <= prg_bank_whole_next;
      prg_bank_low   <= prg_bank_low_next;
      prg_bank_high  <= prg_bank_high_next;
    end
  end

  // --------------------------------------------------------------------------
  // Address translation (state before the beat)
  // --------------------------------------------------------------------------
  logic               mapped_c;
  logic [MADDR_W-1:0] maddr_c;
  logic               hit_c;
  logic               chr_none;
  logic               ppu_low;

  assign chr_none = (chr_count == '0);
  assign ppu_low  = (s1_addr[15:13] == 3'b000);

  always_comb begin
    mapped_c = 1'b0;
    maddr_c  = '0;
    hit_c    = 1'b0;
    case (cmd_t'(s1_cmd))
      CMD_CPU_READ: begin
        if (s1_addr[15:13] == 3'b011) begin
          hit_c = 1'b1;
        end else if (s1_addr[15]) begin
          mapped_c = 1'b1;
          if (!control_reg[3]) maddr_c = {prg_bank_whole, s1_addr[14:0]};
          else if (!s1_addr[14]) maddr_c = {prg_bank_low, s1_addr[13:0]};
          else maddr_c = {prg_bank_high, s1_addr[13:0]};
        end
      end
      CMD_PPU_READ: begin
        if (ppu_low) begin
          mapped_c = 1'b1;
          if (chr_none) maddr_c = MADDR_W'(s1_addr[12:0]);
          else if (!control_reg[4]) maddr_c = MADDR_W'({chr_bank_whole[4:1], s1_addr[12:0]});
          else if (!s1_addr[12]) maddr_c = MADDR_W'({chr_bank_low, s1_addr[11:0]});
          else maddr_c = MADDR_W'({chr_bank_high, s1_addr[11:0]});
        end
      end
      CMD_PPU_WRITE: begin
        if (ppu_low && chr_none) begin
          mapped_c = 1'b1;
          maddr_c  = MADDR_W'(s1_addr[12:0]);
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.mapped         <= mapped_c;
      rsp.mapped_address <= maddr_c;
      rsp.ram_hit        <= hit_c;
      rsp.read_data      <= hit_c ? s1_rdata : '0;
      rsp.mirror_mode    <= control_reg_next[1:0];
    end
  end

  assign rsp.valid = rsp_valid;

`ifndef SYNTHESIS
  // no beat may enter while the RAM sweep runs
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("beat accepted during RAM clearing");

  // serial counter commits on the fifth beat, never counts past it
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    shift_count <= SHIFT_LAST)
    else $error("shift count out of range");

  // a stalled stage 1 beat keeps its contents
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_cmd) && $stable(s1_addr))
    else $error("stage 1 beat lost while stalled");

  // coming out of reset the sweep starts and control is at its reset value
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> clearing && control_reg == CONTROL_RESET && !s1_valid)
    else $error("bad state after reset");

  // a result never claims both a work RAM hit and a mapped access
  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.ram_hit |-> !rsp.mapped)
    else $error("ram hit and mapped both set");
`endif

endmodule
